// File: hdl/cpg_pkg.sv
// ---------------------------------------------------------------------------
// Circle point generator package
// Shared codes, field widths and the modulo-255 color helper.
// ---------------------------------------------------------------------------
`default_nettype none

package cpg_pkg;

    // Fixed widths of the result fields
    localparam int PIX_W   = 13;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 12;
    localparam int MOD_W   = 24;

    // Points per step word: two groups of eight octant points
    localparam int POINTS_PER_STEP = 16;
    localparam int POINT_CNT_W     = 4;

    // Image size after reset
    localparam logic [CFG_W-1:0] IMAGE_SIZE_RESET = 12'd1024;

    // Color limit
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cpg_cmd_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cpg_reg_t;

    // Remainder by 255 of an unsigned value: fold bytes, since 256 = 1 mod 255
    function automatic logic [COLOR_W-1:0] mod255(input logic [MOD_W-1:0] v);
        logic [9:0] s1;
        logic [8:0] s2;
        logic [8:0] s3;
        s1 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]);
        s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
        s3 = (s2 >= 9'd255) ? (s2 - 9'd255) : s2;
        return s3[COLOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/cpg_front.sv
// ---------------------------------------------------------------------------
// Circle point generator front end
// Accepts command words, holds the circle state and runs one midpoint
// update per step, handing the step job to the step queue.
// ---------------------------------------------------------------------------
`default_nettype none

module cpg_front
    import cpg_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int JOB_W      = 6 * COORD_BITS + 9
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [COORD_BITS-1:0] center_x,
    input  wire logic [COORD_BITS-1:0] center_y,
    input  wire logic [COORD_BITS-1:0] radius,
    input  wire logic                  q_full,
    output logic                       q_push,
    output logic [JOB_W-1:0]           q_data
);

    localparam int OW = COORD_BITS + 2;   // octant coordinate, signed
    localparam int DW = COORD_BITS + 7;   // decision value, signed

    logic [COORD_BITS-1:0] center_col_reg;
    logic [COORD_BITS-1:0] center_row_reg;
    logic signed [OW-1:0]  ox_reg;
    logic signed [OW-1:0]  oy_reg;
    logic signed [DW-1:0]  dec_reg;
    logic                  active_reg;

    logic                  accept;
    logic                  is_start;
    logic signed [OW-1:0]  nx;
    logic signed [OW-1:0]  ny;
    logic signed [DW-1:0]  nd;
    logic signed [DW-1:0]  nx_ext;
    logic signed [DW-1:0]  ny_ext;
    logic signed [DW-1:0]  rad_ext;
    logic                  done;

    // Take a word whenever the queue has room
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign is_start = (cpg_cmd_t'(command) == CMD_START);

    // Midpoint update of the running octant
    always_comb
    begin
        nx      = ox_reg + OW'(1);
        nx_ext  = DW'(nx);
        rad_ext = DW'({1'b0, radius});
        if (dec_reg > 0)
        begin
            ny     = oy_reg - OW'(1);
            ny_ext = DW'(ny);
            nd     = dec_reg + ((nx_ext - ny_ext) <<< 2) + DW'(10);
        end
        else
        begin
            ny     = oy_reg;
            ny_ext = DW'(ny);
            nd     = dec_reg + (nx_ext <<< 2) + DW'(6);
        end
        done = (ny < nx);
    end

    // Hand a step to the back end only while a circle runs
    assign q_push = accept && !is_start && active_reg;
    assign q_data = {center_col_reg, center_row_reg, ox_reg, oy_reg, nx, ny, done};

    // Circle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            ox_reg         <= '0;
            oy_reg         <= '0;
            dec_reg        <= '0;
            active_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (is_start)
            begin
                center_col_reg <= center_x;
                center_row_reg <= center_y;
                ox_reg         <= '0;
                oy_reg         <= OW'({1'b0, radius});
                dec_reg        <= DW'(3) - (rad_ext <<< 1);
                active_reg     <= 1'b1;
            end
            else if (active_reg)
            begin
                ox_reg     <= nx;
                oy_reg     <= ny;
                dec_reg    <= nd;
                active_reg <= !done;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/cpg_queue.sv
// ---------------------------------------------------------------------------
// Circle point generator step queue
// Two-entry queue of step jobs between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module cpg_queue
    import cpg_pkg::*;
#(
    parameter int JOB_W = 75
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [JOB_W-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [JOB_W-1:0]      head
);

    logic [JOB_W-1:0] slot0_reg;
    logic [JOB_W-1:0] slot1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot0_reg;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Shift toward the head on pop, fill the first free slot on push
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= slot1_reg;
            if (push)
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_reg <= push_data;
                end
                else
                begin
                    slot1_reg <= push_data;
                end
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/cpg_back.sv
// ---------------------------------------------------------------------------
// Circle point generator back end
// Walks the sixteen symmetric points of a step job, one per cycle while the
// output is not stalled, and registers each point with its color and in-image flag.
// ---------------------------------------------------------------------------
`default_nettype none

module cpg_back
    import cpg_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int JOB_W      = 6 * COORD_BITS + 9
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire logic [JOB_W-1:0]        q_data,
    output logic                         q_pop,
    input  wire logic [CFG_W-1:0]        image_width,
    input  wire logic [CFG_W-1:0]        image_height,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [PIX_W-1:0]      pixel_x,
    output logic signed [PIX_W-1:0]      pixel_y,
    output logic [COLOR_W-1:0]           red,
    output logic [COLOR_W-1:0]           green,
    output logic [COLOR_W-1:0]           blue,
    output logic                         in_image,
    output logic                         last,
    output logic                         done_res
);

    localparam int OW    = COORD_BITS + 2;
    localparam int SUM_W = (COORD_BITS + 3 > PIX_W) ? COORD_BITS + 3 : PIX_W;

    // Current job
    logic [JOB_W-1:0]       job_reg;
    logic                   job_valid_reg;
    logic [POINT_CNT_W-1:0] cnt_reg;

    logic [COORD_BITS-1:0]  j_cx;
    logic [COORD_BITS-1:0]  j_cy;
    logic signed [OW-1:0]   j_ox0;
    logic signed [OW-1:0]   j_oy0;
    logic signed [OW-1:0]   j_nx;
    logic signed [OW-1:0]   j_ny;
    logic                   j_done;

    logic                   advance;
    logic                   final_point;
    logic signed [OW-1:0]   ox;
    logic signed [OW-1:0]   oy;
    logic signed [OW-1:0]   da;
    logic signed [OW-1:0]   db;
    logic signed [SUM_W-1:0] cx_ext;
    logic signed [SUM_W-1:0] cy_ext;
    logic signed [SUM_W-1:0] px;
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] h_ext;
    logic                   point_in;
    logic [OW-1:0]          ox_mag;
    logic [OW-1:0]          oy_mag;
    logic [COLOR_W-1:0]     ox_mod;
    logic [COLOR_W-1:0]     oy_mod;
    logic [COLOR_W-1:0]     red_c;
    logic [COLOR_W-1:0]     green_c;

    assign {j_cx, j_cy, j_ox0, j_oy0, j_nx, j_ny, j_done} = job_reg;

    // Advance one point when the output register is free or drains
    assign advance     = job_valid_reg && (!out_valid || !out_stall);
    assign final_point = (cnt_reg == POINT_CNT_W'(POINTS_PER_STEP - 1));
    assign q_pop       = q_valid && (!job_valid_reg || (advance && final_point));

    // Pick the octant point: group by the high bit, mirror by the low bits
    always_comb
    begin
        ox       = cnt_reg[3] ? j_nx : j_ox0;
        oy       = cnt_reg[3] ? j_ny : j_oy0;
        da       = cnt_reg[2] ? oy : ox;
        db       = cnt_reg[2] ? ox : oy;
        cx_ext   = SUM_W'({1'b0, j_cx});
        cy_ext   = SUM_W'({1'b0, j_cy});
        px       = cnt_reg[0] ? (cx_ext - SUM_W'(da)) : (cx_ext + SUM_W'(da));
        py       = cnt_reg[1] ? (cy_ext - SUM_W'(db)) : (cy_ext + SUM_W'(db));
        w_ext    = SUM_W'({1'b0, image_width});
        h_ext    = SUM_W'({1'b0, image_height});
        point_in = (px >= 0) && (py >= 0) && (px < w_ext) && (py < h_ext);
    end

    // Colors: signed remainder by 255, taken to eight bits
    always_comb
    begin
        ox_mag  = ox[OW-1] ? OW'(-ox) : OW'(ox);
        oy_mag  = oy[OW-1] ? OW'(-oy) : OW'(oy);
        ox_mod  = mod255(MOD_W'(ox_mag));
        oy_mod  = mod255(MOD_W'(oy_mag));
        red_c   = ox[OW-1] ? (COLOR_W'(0) - ox_mod) : ox_mod;
        green_c = oy[OW-1] ? (COLOR_W'(0) - oy_mod) : oy_mod;
    end

    // Job register and point counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else if (q_pop)
        begin
            job_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= cnt_reg + POINT_CNT_W'(1);
            if (final_point)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (advance)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_x  <= px[PIX_W-1:0];
            pixel_y  <= py[PIX_W-1:0];
            red      <= red_c;
            green    <= green_c;
            blue     <= COLOR_MAX - red_c;
            in_image <= point_in;
            last     <= final_point;
            done_res <= j_done;
        end
    end

endmodule

`default_nettype wire

// File: hdl/circle_point_generator.sv
// Path: a step word goes through a queue slot and the job register; each point is then registered.
// Throughput: one point per cycle while the output is not stalled; a step word yields sixteen, so
// the rate of steps is set by the single-point back-end walker.
// Start words produce no output; a two-entry step queue decouples the two ends.
// Reset (rst_n low, asynchronous): no circle runs, queue and outputs empty, image size 1024.
// ---------------------------------------------------------------------------
// Circle point generator
// Midpoint circle rasterizer with an APB register port for the image size.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_point_generator
    import cpg_pkg::*;
#(
    parameter int COORD_BITS = 11
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Command channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [COORD_BITS-1:0] center_x,
    input  wire logic [COORD_BITS-1:0] center_y,
    input  wire logic [COORD_BITS-1:0] radius,
    // Point channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [PIX_W-1:0]    pixel_x,
    output logic signed [PIX_W-1:0]    pixel_y,
    output logic [COLOR_W-1:0]         red,
    output logic [COLOR_W-1:0]         green,
    output logic [COLOR_W-1:0]         blue,
    output logic                       in_image,
    output logic                       last,
    output logic                       done_res
);

    localparam int JOB_W = 2 * COORD_BITS + 4 * (COORD_BITS + 2) + 1;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic             cfg_write;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [JOB_W-1:0] q_push_data;
    logic [JOB_W-1:0] q_head;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_SIZE_RESET;
            image_height_reg <= IMAGE_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cpg_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_W-1:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cpg_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    cpg_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    cpg_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    cpg_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!q_empty),
        .q_data       (q_head),
        .q_pop        (q_pop),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .in_image     (in_image),
        .last         (last),
        .done_res     (done_res)
    );

    // Never push a step into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("step pushed into full queue");

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("step popped from empty queue");

    // Blue is always the complement of red
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blue == (COLOR_MAX - red)))
        else $error("blue does not match red");

endmodule

`default_nettype wire

// File: test/circle_point_generator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle point generator testbench
// Drives start and step words, mirrors the midpoint circle walk in a local
// tracer, and checks every point word against the traced points in order.
// The image size is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------

module circle_point_generator_tb;

    import cpg_pkg::*;

    localparam int COORD_W    = 11;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 8;
    localparam int DRAIN_CYC   = 20;
    localparam int PHASE_WORDS = 13;
    localparam int NUM_PHASES  = 6;

    typedef struct packed
    {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
        logic                    in_img;
        logic                    is_last;
        logic                    fin;
    } point_t;

    typedef struct packed
    {
        cpg_cmd_t           cmd;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] rad;
        logic               typed;
        point_t             first;
    } plan_row_t;

    localparam int PLAN_LEN = 23;

    // Directed words; typed rows carry the first point of the step
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // step with no circle running
        '{CMD_STEP,  11'd1234, 11'd5,    11'd77,   1'b0, '0},
        // zero radius at the origin, then a step past the end
        '{CMD_START, 11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b1,
          '{13'sd0, 13'sd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0, 1'b1}},
        '{CMD_STEP,  11'd2047, 11'd2047, 11'd2047, 1'b0, '0},
        // largest center and radius
        '{CMD_START, 11'd2047, 11'd2047, 11'd2047, 1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b1,
          '{13'sd2047, 13'sd4094, 8'd0, 8'd7, 8'd255, 1'b0, 1'b0, 1'b0}},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        // restart while running, then run a small circle out
        '{CMD_START, 11'd100,  11'd50,   11'd3,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        // circle crossing the top and left edges
        '{CMD_START, 11'd5,    11'd5,    11'd20,   1'b0, '0},
        '{CMD_STEP,  11'd2047, 11'd0,    11'd2047, 1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd2047, 11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_START, 11'd1024, 11'd0,    11'd1500, 1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_START, 11'd0,    11'd2047, 11'd1,    1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0},
        '{CMD_START, 11'd2047, 11'd0,    11'd2047, 1'b0, '0},
        '{CMD_STEP,  11'd0,    11'd0,    11'd0,    1'b0, '0}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic                    command;
    logic [COORD_W-1:0]      center_x;
    logic [COORD_W-1:0]      center_y;
    logic [COORD_W-1:0]      radius;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic                    in_image;
    logic                    last;
    logic                    done_res;

    // Traced circle state and image size
    int       img_w;
    int       img_h;
    int       ctr_col;
    int       ctr_row;
    int       walk_x;
    int       walk_y;
    int       walk_d;
    bit       circle_active;

    point_t   traced_points[$];
    int       err_count;
    int       live_words;
    int       idle_cycles;
    bit       calm;

    circle_point_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .in_image  (in_image),
        .last      (last),
        .done_res  (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Build one plotted point from pixel position and octant coordinates
    function automatic point_t plot_point(int px, int py, int ox, int oy,
                                          bit fin, bit is_last);
        point_t p;
        int     rr;
        int     gg;
        rr = ox % 255;
        gg = oy % 255;
        p.px      = PIX_W'(px);
        p.py      = PIX_W'(py);
        p.red     = COLOR_W'(rr);
        p.green   = COLOR_W'(gg);
        p.blue    = COLOR_W'(255 - rr);
        p.in_img  = (px >= 0) && (py >= 0) && (px < img_w) && (py < img_h);
        p.is_last = is_last;
        p.fin     = fin;
        return p;
    endfunction

    // Queue the eight mirrored points of one octant position
    function automatic void mirror_octants(int ox, int oy, bit fin, int base);
        int a;
        int b;
        int px;
        int py;
        for (int k = 0; k < 8; k++)
        begin
            a  = (k < 4) ? ox : oy;
            b  = (k < 4) ? oy : ox;
            px = ctr_col + ((k % 2 == 1) ? -a : a);
            py = ctr_row + (((k / 2) % 2 == 1) ? -b : b);
            traced_points.push_back(plot_point(px, py, ox, oy, fin, base + k == 15));
        end
    endfunction

    // Advance the traced circle by one accepted word
    function automatic void trace_word(cpg_cmd_t cmd, logic [COORD_W-1:0] cx,
                                       logic [COORD_W-1:0] cy, logic [COORD_W-1:0] rad);
        int  nx;
        int  ny;
        int  nd;
        bit  fin;
        if (cmd == CMD_START)
        begin
            ctr_col       = int'(cx);
            ctr_row       = int'(cy);
            walk_x        = 0;
            walk_y        = int'(rad);
            walk_d        = 3 - 2 * walk_y;
            circle_active = 1'b1;
        end
        else if (circle_active)
        begin
            nx = walk_x + 1;
            ny = walk_y;
            if (walk_d > 0)
            begin
                ny = walk_y - 1;
                nd = walk_d + 4 * (nx - ny) + 10;
            end
            else
            begin
                nd = walk_d + 4 * nx + 6;
            end
            fin = ny < nx;
            mirror_octants(walk_x, walk_y, fin, 0);
            mirror_octants(nx, ny, fin, 8);
            walk_x        = nx;
            walk_y        = ny;
            walk_d        = nd;
            circle_active = !fin;
        end
    endfunction

    // Present one word, hold it until accepted, then trace it
    task automatic send_word(cpg_cmd_t cmd, logic [COORD_W-1:0] cx,
                             logic [COORD_W-1:0] cy, logic [COORD_W-1:0] rad);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= cx;
        center_y <= cy;
        radius   <= rad;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_START || circle_active)
            live_words++;
        trace_word(cmd, cx, cy, rad);
    endtask

    // Wait until every traced point has come out, plus a short pause
    task automatic settle();
        in_valid <= 1'b0;
        while (traced_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Setup and access cycle of one register write
    task automatic write_reg(cpg_reg_t idx, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_w = int'(value);
        else
            img_h = int'(value);
    endtask

    // One random circle: start, steps with random early restarts, stray steps
    task automatic run_circle();
        logic [COORD_W-1:0] rad;
        int                 step_cap;
        int                 n;
        if ($urandom_range(0, 99) < 8)
            send_word(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        rad = ($urandom_range(0, 99) < 85) ? COORD_W'($urandom_range(0, 40))
                                           : COORD_W'($urandom_range(0, 2047));
        send_word(CMD_START, COORD_W'($urandom_range(0, 2047)),
                  COORD_W'($urandom_range(0, 2047)), rad);
        step_cap = (rad > 40) ? $urandom_range(1, 8) : 2000;
        n = 0;
        while (circle_active && n < step_cap && $urandom_range(0, 99) >= 4)
        begin
            send_word(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            n++;
        end
        if (!circle_active && $urandom_range(0, 99) < 20)
            send_word(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Stimulus and final verdict
    initial
    begin
        int widths [NUM_PHASES];
        int heights[NUM_PHASES];
        int phase_start;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        command   <= CMD_START;
        center_x  <= '0;
        center_y  <= '0;
        radius    <= '0;
        img_w         = int'(IMAGE_SIZE_RESET);
        img_h         = int'(IMAGE_SIZE_RESET);
        ctr_col       = 0;
        ctr_row       = 0;
        walk_x        = 0;
        walk_y        = 0;
        walk_d        = 0;
        circle_active = 1'b0;
        err_count     = 0;
        live_words    = 0;
        calm          = 1'b0;
        widths  = '{2048, 1, 0, 2048, 640, 0};
        heights = '{2048, 1, 2048, 0, 480, 0};
        widths[5]  = $urandom_range(1, 2048);
        heights[5] = $urandom_range(1, 2048);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset image size
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            send_word(PLAN[i].cmd, PLAN[i].cx, PLAN[i].cy, PLAN[i].rad);
            if (PLAN[i].typed)
                traced_points[traced_points.size() - 16] = PLAN[i].first;
        end

        // Random circles, one image size per phase; one phase runs without gaps
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            calm = (ph == 4);
            write_reg(REG_IMAGE_WIDTH, CFG_W'(widths[ph]));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(heights[ph]));
            phase_start = live_words;
            while (live_words - phase_start < PHASE_WORDS)
                run_circle();
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Random back-pressure on the point channel
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 34);
    end

    task automatic check_field(string name, int exp_v, int got_v, int idx);
        if (exp_v != got_v)
        begin
            err_count++;
            $display("%0t point %0d %s expected %0d got %0d",
                     $time, idx, name, exp_v, got_v);
        end
    endtask

    // Compare each accepted point word with the oldest traced point
    int     point_idx = 0;
    always @(posedge clk)
    begin
        point_t exp_p;
        if (rst_n && out_valid && !out_stall)
        begin
            if (traced_points.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected point expected none got (%0d,%0d)",
                         $time, pixel_x, pixel_y);
            end
            else
            begin
                exp_p = traced_points.pop_front();
                check_field("pixel_x",  int'(exp_p.px),      int'(pixel_x),  point_idx);
                check_field("pixel_y",  int'(exp_p.py),      int'(pixel_y),  point_idx);
                check_field("red",      int'(exp_p.red),     int'(red),      point_idx);
                check_field("green",    int'(exp_p.green),   int'(green),    point_idx);
                check_field("blue",     int'(exp_p.blue),    int'(blue),     point_idx);
                check_field("in_image", int'(exp_p.in_img),  int'(in_image), point_idx);
                check_field("last",     int'(exp_p.is_last), int'(last),     point_idx);
                check_field("done_res", int'(exp_p.fin),     int'(done_res), point_idx);
            end
            point_idx++;
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
